// ===== src/hrp_pkg.sv =====
// hrp_pkg: shared types, character codes and helper functions for the
// http request header parser. No dependencies.
package hrp_pkg;

    // default queue depths
    localparam int ITEM_QUEUE_DEPTH   = 2;
    localparam int RESULT_QUEUE_DEPTH = 2;

    // character codes
    localparam logic [7:0] CHAR_HT    = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SP    = 8'h20;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_H     = 8'h48;
    localparam logic [7:0] CHAR_P     = 8'h50;
    localparam logic [7:0] CHAR_T     = 8'h54;
    localparam logic [7:0] CHAR_CTL_MAX = 8'd31;
    localparam logic [7:0] CHAR_DEL   = 8'd127;

    localparam logic [15:0] VERSION_MAX = 16'hFFFF;

    // parser states, codes as seen on the state register
    typedef enum logic [4:0] {
        ST_METHOD_START = 5'd0,
        ST_METHOD       = 5'd1,
        ST_URI_START    = 5'd2,
        ST_URI          = 5'd3,
        ST_VER_H        = 5'd4,
        ST_VER_T1       = 5'd5,
        ST_VER_T2       = 5'd6,
        ST_VER_P        = 5'd7,
        ST_VER_SLASH    = 5'd8,
        ST_MAJOR_START  = 5'd9,
        ST_MAJOR        = 5'd10,
        ST_MINOR_START  = 5'd11,
        ST_MINOR        = 5'd12,
        ST_NL1          = 5'd13,
        ST_LINE_START   = 5'd14,
        ST_LWS          = 5'd15,
        ST_HNAME        = 5'd16,
        ST_SPACE_VALUE  = 5'd17,
        ST_HVALUE       = 5'd18,
        ST_NL2          = 5'd19,
        ST_NL3          = 5'd20,
        ST_BODY         = 5'd21
    } parse_state_t;

    typedef enum logic [1:0] {
        RS_CONT = 2'd0,
        RS_DONE = 2'd1,
        RS_ERR  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        CL_NONE   = 3'd0,
        CL_METHOD = 3'd1,
        CL_URI    = 3'd2,
        CL_HNAME  = 3'd3,
        CL_HVALUE = 3'd4,
        CL_BODY   = 3'd5
    } byte_class_t;

    // one incoming request byte
    typedef struct packed {
        logic [7:0]  data_byte;
        logic [15:0] bytes_remaining;
        logic        restart;
    } request_t;

    // one result
    typedef struct packed {
        status_t     status;
        byte_class_t byte_class;
        logic        new_header;
        logic [7:0]  out_byte;
        logic [15:0] version_major;
        logic [15:0] version_minor;
    } result_t;

    // request byte after classification by the front end
    typedef struct packed {
        logic [7:0] data_byte;
        logic       more;      // bytes still follow this one
        logic       restart;
        logic       tok;       // token character
        logic       ctl;       // control character
        logic       dig;       // decimal digit
        logic [3:0] digit;
    } cls_item_t;

    function automatic logic is_ctl(input logic [7:0] b);
        return (b <= CHAR_CTL_MAX) || (b == CHAR_DEL);
    endfunction

    function automatic logic is_sep(input logic [7:0] b);
        logic r;
        case (b) inside
            8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C, 8'h22,
            8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D, 8'h20, 8'h09:
                r = 1'b1;
            default:
                r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_tok(input logic [7:0] b);
        return !b[7] && !is_ctl(b) && !is_sep(b);
    endfunction

    // acc * 10 + d, saturating at 16 bits
    function automatic logic [15:0] acc_digit(input logic [15:0] acc, input logic [3:0] d);
        logic [19:0] v;
        v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {16'd0, d};
        return (v > {4'd0, VERSION_MAX}) ? VERSION_MAX : v[15:0];
    endfunction

endpackage

// ===== src/hrp_fifo.sv =====
// hrp_fifo: small first-word-fall-through queue on flip-flops.
// Uses no package; depth must be at least 2.
module hrp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== src/hrp_front.sv =====
// hrp_front: accepts request bytes, classifies them and queues them for the parser.
// Depends on hrp_pkg and hrp_fifo.
module hrp_front #(
    parameter int DEPTH = hrp_pkg::ITEM_QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  hrp_pkg::request_t   request,
    output logic                full,
    output hrp_pkg::cls_item_t  item,
    output logic                item_valid,
    input  logic                item_take
);

    localparam int ITEM_W = $bits(hrp_pkg::cls_item_t);

    hrp_pkg::cls_item_t cls;
    logic [ITEM_W-1:0]  q_rd_data;
    logic               q_empty;

    // character classification of the incoming byte
    always_comb
    begin
        cls.data_byte = request.data_byte;
        cls.more      = (request.bytes_remaining != '0);
        cls.restart   = request.restart;
        cls.tok       = hrp_pkg::is_tok(request.data_byte);
        cls.ctl       = hrp_pkg::is_ctl(request.data_byte);
        cls.dig       = (request.data_byte >= hrp_pkg::CHAR_ZERO)
                     && (request.data_byte <= hrp_pkg::CHAR_NINE);
        cls.digit     = request.data_byte[3:0];
    end

    // decoupling queue toward the parser
    hrp_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (DEPTH)
    ) u_item_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (cls),
        .full    (full),
        .pop     (item_take),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    assign item       = hrp_pkg::cls_item_t'(q_rd_data);
    assign item_valid = !q_empty;

endmodule

// ===== src/hrp_back.sv =====
// hrp_back: request parser state machine and the result queue.
// Depends on hrp_pkg and hrp_fifo.
module hrp_back #(
    parameter int DEPTH = hrp_pkg::RESULT_QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  hrp_pkg::cls_item_t item,
    input  logic               item_valid,
    output logic               item_take,
    output hrp_pkg::result_t   res_next,
    output hrp_pkg::result_t   result,
    output logic               empty,
    input  logic               pop
);

    localparam int RES_W = $bits(hrp_pkg::result_t);

    hrp_pkg::parse_state_t state_reg, state_next;
    logic                  seen_reg, seen_next;
    logic [15:0]           major_reg, major_next;
    logic [15:0]           minor_reg, minor_next;
    hrp_pkg::status_t      status;
    hrp_pkg::byte_class_t  byte_class;
    logic                  new_header;
    logic                  res_full;
    logic [RES_W-1:0]      res_rd_data;
    logic                  is_sp_ht;

    assign item_take = item_valid && !res_full;
    assign is_sp_ht  = (item.data_byte == hrp_pkg::CHAR_SP)
                    || (item.data_byte == hrp_pkg::CHAR_HT);

    // next state and version accumulators
    always_comb
    begin
        state_next = state_reg;
        seen_next  = seen_reg;
        major_next = major_reg;
        minor_next = minor_reg;
        if (item.restart)
        begin
            state_next = hrp_pkg::ST_METHOD_START;
            seen_next  = 1'b0;
            major_next = '0;
            minor_next = '0;
        end
        else
        begin
            unique case (state_reg)
                hrp_pkg::ST_METHOD_START:
                begin
                    if (item.tok) state_next = hrp_pkg::ST_METHOD;
                end
                hrp_pkg::ST_METHOD:
                begin
                    if (item.data_byte == hrp_pkg::CHAR_SP) state_next = hrp_pkg::ST_URI;
                end
                hrp_pkg::ST_URI_START:
                begin
                    if (!item.ctl) state_next = hrp_pkg::ST_URI;
                end
                hrp_pkg::ST_URI:
                begin
                    if (item.data_byte == hrp_pkg::CHAR_SP) state_next = hrp_pkg::ST_VER_H;
                end
                hrp_pkg::ST_VER_H:
                begin
                    if (item.data_byte == hrp_pkg::CHAR_H) state_next = hrp_pkg::ST_VER_T1;
                end
                hrp_pkg::ST_VER_T1:
                begin
                    if (item.data_byte == hrp_pkg::CHAR_T) state_next = hrp_pkg::ST_VER_T2;
                end
                hrp_pkg::ST_VER_T2:
                begin
                    if (item.data_byte == hrp_pkg::CHAR_T) state_next = hrp_pkg::ST_VER_P;
                end
                hrp_pkg::ST_VER_P:
                begin
                    if (item.data_byte == hrp_pkg::CHAR_P) state_next = hrp_pkg::ST_VER_SLASH;
                end
                hrp_pkg::ST_VER_SLASH:
                begin
                    if (item.data_byte == hrp_pkg::CHAR_SLASH)
                    begin
                        major_next = '0;
                        minor_next = '0;
                        state_next = hrp_pkg::ST_MAJOR_START;
                    end
                end
                hrp_pkg::ST_MAJOR_START:
                begin
                    if (item.dig)
                    begin
                        major_next = hrp_pkg::acc_digit(major_reg, item.digit);
                        state_next = hrp_pkg::ST_MAJOR;
                    end
                end
                hrp_pkg::ST_MAJOR:
                begin
                    if (item.data_byte == hrp_pkg::CHAR_DOT)
                    begin
                        state_next = hrp_pkg::ST_MINOR_START;
                    end
                    else if (item.dig)
                    begin
                        major_next = hrp_pkg::acc_digit(major_reg, item.digit);
                    end
                end
                hrp_pkg::ST_MINOR_START:
                begin
                    if (item.dig)
                    begin
                        minor_next = hrp_pkg::acc_digit(minor_reg, item.digit);
                        state_next = hrp_pkg::ST_MINOR;
                    end
                end
                hrp_pkg::ST_MINOR:
                begin
                    if (item.data_byte == hrp_pkg::CHAR_CR)
                    begin
                        state_next = hrp_pkg::ST_NL1;
                    end
                    else if (item.dig)
                    begin
                        minor_next = hrp_pkg::acc_digit(minor_reg, item.digit);
                    end
                end
                hrp_pkg::ST_NL1, hrp_pkg::ST_NL2:
                begin
                    if (item.data_byte == hrp_pkg::CHAR_LF) state_next = hrp_pkg::ST_LINE_START;
                end
                hrp_pkg::ST_LINE_START:
                begin
                    if (item.data_byte == hrp_pkg::CHAR_CR)
                    begin
                        state_next = hrp_pkg::ST_NL3;
                    end
                    else if (seen_reg && is_sp_ht)
                    begin
                        state_next = hrp_pkg::ST_LWS;
                    end
                    else if (item.tok)
                    begin
                        seen_next  = 1'b1;
                        state_next = hrp_pkg::ST_HNAME;
                    end
                end
                hrp_pkg::ST_LWS:
                begin
                    if (item.data_byte == hrp_pkg::CHAR_CR)
                    begin
                        state_next = hrp_pkg::ST_NL2;
                    end
                    else if (!is_sp_ht && !item.ctl)
                    begin
                        state_next = hrp_pkg::ST_HVALUE;
                    end
                end
                hrp_pkg::ST_HNAME:
                begin
                    if (item.data_byte == hrp_pkg::CHAR_COLON) state_next = hrp_pkg::ST_SPACE_VALUE;
                end
                hrp_pkg::ST_SPACE_VALUE:
                begin
                    if (item.data_byte == hrp_pkg::CHAR_SP) state_next = hrp_pkg::ST_HVALUE;
                end
                hrp_pkg::ST_HVALUE:
                begin
                    if (item.data_byte == hrp_pkg::CHAR_CR) state_next = hrp_pkg::ST_NL2;
                end
                hrp_pkg::ST_NL3:
                begin
                    if (item.data_byte == hrp_pkg::CHAR_LF && item.more)
                    begin
                        state_next = hrp_pkg::ST_BODY;
                    end
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
        end
    end

    // result fields for the current byte
    always_comb
    begin
        status     = hrp_pkg::RS_CONT;
        byte_class = hrp_pkg::CL_NONE;
        new_header = 1'b0;
        if (!item.restart)
        begin
            unique case (state_reg)
                hrp_pkg::ST_METHOD_START:
                begin
                    if (item.tok) byte_class = hrp_pkg::CL_METHOD;
                    else status = hrp_pkg::RS_ERR;
                end
                hrp_pkg::ST_METHOD:
                begin
                    if (item.data_byte == hrp_pkg::CHAR_SP) status = hrp_pkg::RS_CONT;
                    else if (item.tok) byte_class = hrp_pkg::CL_METHOD;
                    else status = hrp_pkg::RS_ERR;
                end
                hrp_pkg::ST_URI_START:
                begin
                    if (item.ctl) status = hrp_pkg::RS_ERR;
                    else byte_class = hrp_pkg::CL_URI;
                end
                hrp_pkg::ST_URI:
                begin
                    if (item.data_byte == hrp_pkg::CHAR_SP) status = hrp_pkg::RS_CONT;
                    else if (item.ctl) status = hrp_pkg::RS_ERR;
                    else byte_class = hrp_pkg::CL_URI;
                end
                hrp_pkg::ST_VER_H:
                begin
                    if (item.data_byte != hrp_pkg::CHAR_H) status = hrp_pkg::RS_ERR;
                end
                hrp_pkg::ST_VER_T1, hrp_pkg::ST_VER_T2:
                begin
                    if (item.data_byte != hrp_pkg::CHAR_T) status = hrp_pkg::RS_ERR;
                end
                hrp_pkg::ST_VER_P:
                begin
                    if (item.data_byte != hrp_pkg::CHAR_P) status = hrp_pkg::RS_ERR;
                end
                hrp_pkg::ST_VER_SLASH:
                begin
                    if (item.data_byte != hrp_pkg::CHAR_SLASH) status = hrp_pkg::RS_ERR;
                end
                hrp_pkg::ST_MAJOR_START, hrp_pkg::ST_MINOR_START:
                begin
                    if (!item.dig) status = hrp_pkg::RS_ERR;
                end
                hrp_pkg::ST_MAJOR:
                begin
                    if (item.data_byte != hrp_pkg::CHAR_DOT && !item.dig) status = hrp_pkg::RS_ERR;
                end
                hrp_pkg::ST_MINOR:
                begin
                    if (item.data_byte != hrp_pkg::CHAR_CR && !item.dig) status = hrp_pkg::RS_ERR;
                end
                hrp_pkg::ST_NL1, hrp_pkg::ST_NL2:
                begin
                    if (item.data_byte != hrp_pkg::CHAR_LF) status = hrp_pkg::RS_ERR;
                end
                hrp_pkg::ST_LINE_START:
                begin
                    if (item.data_byte == hrp_pkg::CHAR_CR || (seen_reg && is_sp_ht))
                    begin
                        status = hrp_pkg::RS_CONT;
                    end
                    else if (item.tok)
                    begin
                        new_header = 1'b1;
                        byte_class = hrp_pkg::CL_HNAME;
                    end
                    else
                    begin
                        status = hrp_pkg::RS_ERR;
                    end
                end
                hrp_pkg::ST_LWS:
                begin
                    if (item.data_byte == hrp_pkg::CHAR_CR || is_sp_ht) status = hrp_pkg::RS_CONT;
                    else if (item.ctl) status = hrp_pkg::RS_ERR;
                    else byte_class = hrp_pkg::CL_HVALUE;
                end
                hrp_pkg::ST_HNAME:
                begin
                    if (item.data_byte == hrp_pkg::CHAR_COLON) status = hrp_pkg::RS_CONT;
                    else if (item.tok) byte_class = hrp_pkg::CL_HNAME;
                    else status = hrp_pkg::RS_ERR;
                end
                hrp_pkg::ST_SPACE_VALUE:
                begin
                    if (item.data_byte != hrp_pkg::CHAR_SP) status = hrp_pkg::RS_ERR;
                end
                hrp_pkg::ST_HVALUE:
                begin
                    if (item.data_byte == hrp_pkg::CHAR_CR) status = hrp_pkg::RS_CONT;
                    else if (item.ctl) status = hrp_pkg::RS_ERR;
                    else byte_class = hrp_pkg::CL_HVALUE;
                end
                hrp_pkg::ST_NL3:
                begin
                    if (item.data_byte != hrp_pkg::CHAR_LF) status = hrp_pkg::RS_ERR;
                    else if (!item.more) status = hrp_pkg::RS_DONE;
                end
                hrp_pkg::ST_BODY:
                begin
                    byte_class = hrp_pkg::CL_BODY;
                    status     = item.more ? hrp_pkg::RS_CONT : hrp_pkg::RS_DONE;
                end
                default:
                begin
                    status = hrp_pkg::RS_ERR;
                end
            endcase
        end
    end

    // assemble the result
    always_comb
    begin
        res_next.status        = status;
        res_next.byte_class    = byte_class;
        res_next.new_header    = new_header;
        res_next.out_byte      = item.data_byte;
        res_next.version_major = major_next;
        res_next.version_minor = minor_next;
    end

    // parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hrp_pkg::ST_METHOD_START;
            seen_reg  <= 1'b0;
            major_reg <= '0;
            minor_reg <= '0;
        end
        else if (item_take)
        begin
            state_reg <= state_next;
            seen_reg  <= seen_next;
            major_reg <= major_next;
            minor_reg <= minor_next;
        end
    end

    // result queue
    hrp_fifo #(
        .WIDTH (RES_W),
        .DEPTH (DEPTH)
    ) u_result_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (item_take),
        .wr_data (res_next),
        .full    (res_full),
        .pop     (pop),
        .rd_data (res_rd_data),
        .empty   (empty)
    );

    assign result = hrp_pkg::result_t'(res_rd_data);

endmodule

// ===== src/http_request_header_parser.sv =====
// http_request_header_parser: top level, front classifier plus back parser.
// Depends on hrp_pkg, hrp_fifo, hrp_front and hrp_back.

// Byte-at-a-time HTTP/1.1 request parser. Each pushed request carries one byte,
// the count of bytes still to follow and a restart flag; each yields exactly one
// result tagging the byte (method, uri, header name, header value, body or none),
// flagging the first byte of each header and giving continue, complete or error,
// with the saturating major.minor version seen so far. Throughput is one byte per
// cycle while the result queue has room: the parser state machine updates its
// state once per accepted byte. A pushed byte is registered in the classifier
// queue; the parser then writes its result into the result queue, from which
// it can be popped. A byte giving complete or error leaves the parser state as
// it was; later bytes are parsed on from that state until a restart request.
module http_request_header_parser #(
    parameter int ITEM_DEPTH   = hrp_pkg::ITEM_QUEUE_DEPTH,
    parameter int RESULT_DEPTH = hrp_pkg::RESULT_QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  hrp_pkg::request_t request,
    output logic              full,
    output hrp_pkg::result_t  result,
    output logic              empty,
    input  logic              pop
);

    hrp_pkg::cls_item_t item;
    logic               item_valid;
    logic               item_take;
    hrp_pkg::result_t   res_next;

    // classification and input queue
    hrp_front #(
        .DEPTH (ITEM_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .request    (request),
        .full       (full),
        .item       (item),
        .item_valid (item_valid),
        .item_take  (item_take)
    );

    // parser and result queue
    hrp_back #(
        .DEPTH (RESULT_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_valid (item_valid),
        .item_take  (item_take),
        .res_next   (res_next),
        .result     (result),
        .empty      (empty),
        .pop        (pop)
    );

    // an error result carries no class and no header start
    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.status == hrp_pkg::RS_ERR)
            |-> (result.byte_class == hrp_pkg::CL_NONE && !result.new_header))
        else $error("error result carries a byte class");

    // a header start is always a header name byte
    a_nh_name: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.new_header) |-> (result.byte_class == hrp_pkg::CL_HNAME))
        else $error("new header flag on a non-name byte");

    // a restart clears the version accumulators in its own result
    a_restart_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (item_take && item.restart)
            |-> (res_next.version_major == '0 && res_next.version_minor == '0
                 && res_next.status == hrp_pkg::RS_CONT))
        else $error("restart did not clear the parser");

    // the parser only consumes a queued byte
    a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
        item_take |-> item_valid)
        else $error("parser took a byte from an empty queue");

endmodule

// ===== tb/http_request_header_parser_tb.sv =====
// Self-checking testbench for http_request_header_parser: a directed table of
// request bytes, then random well-formed, broken and noise requests.
// Depends on hrp_pkg and the http_request_header_parser RTL.
`timescale 1ns / 1ps

module http_request_header_parser_tb;

    import hrp_pkg::*;

    // one row of stimulus, with an optional typed-in expected result
    typedef struct packed {
        request_t req;
        logic     typed;
        result_t  want;
    } stim_row_t;

    localparam int RANDOM_ITEMS   = 1300;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int DRAIN_LIMIT    = 5000;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     push = 1'b0;
    request_t request = '0;
    logic     full;
    result_t  result;
    logic     empty;
    logic     pop = 1'b0;

    // parser state as the testbench tracks it
    parse_state_t cur_state = ST_METHOD_START;
    logic         hdr_seen = 1'b0;
    logic [15:0]  major_seen = '0;
    logic [15:0]  minor_seen = '0;

    result_t   awaited_results[$];
    stim_row_t directed_rows[$];
    int        errors = 0;
    int        sent_count = 0;
    int        burst_left = 0;

    // receiver side controls
    logic        stall_toggle = 1'b0;
    logic        stall_seen = 1'b0;
    int          hold_cycles = 0;
    logic [15:0] rx_cycle = '0;

    http_request_header_parser u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .request (request),
        .full    (full),
        .result  (result),
        .empty   (empty),
        .pop     (pop)
    );

    always #10 clk = ~clk;

    // character classes
    function automatic logic is_control_byte(input logic [7:0] b);
        return (b <= 8'd31) || (b == CHAR_DEL);
    endfunction

    function automatic logic is_separator_byte(input logic [7:0] b);
        logic r;
        case (b)
            "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"",
            "/", "[", "]", "?", "=", "{", "}", CHAR_SP, CHAR_HT:
                r = 1'b1;
            default:
                r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_token_byte(input logic [7:0] b);
        return (b <= 8'd127) && !is_control_byte(b) && !is_separator_byte(b);
    endfunction

    function automatic logic is_digit_byte(input logic [7:0] b);
        return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    endfunction

    // decimal accumulate, clamped to 16 bits
    function automatic logic [15:0] add_decimal_digit(input logic [15:0] acc,
                                                      input logic [7:0] b);
        int unsigned v;
        v = 32'(acc);
        v = v * 10 + 32'(b - CHAR_ZERO);
        return (v > 65535) ? 16'hFFFF : v[15:0];
    endfunction

    // advance the tracked parser by one request and give the result it yields
    function automatic result_t parse_byte(input request_t r);
        result_t      res;
        logic [7:0]   b;
        status_t      st;
        byte_class_t  cl;
        logic         nh;
        parse_state_t nxt;
        b = r.data_byte;
        st = RS_CONT;
        cl = CL_NONE;
        nh = 1'b0;
        nxt = cur_state;
        if (r.restart)
        begin
            cur_state = ST_METHOD_START;
            hdr_seen = 1'b0;
            major_seen = '0;
            minor_seen = '0;
        end
        else
        begin
            case (cur_state)
                ST_METHOD_START:
                    if (is_token_byte(b))
                    begin
                        nxt = ST_METHOD;
                        cl = CL_METHOD;
                    end
                    else
                        st = RS_ERR;
                ST_METHOD:
                    if (b == CHAR_SP)
                        nxt = ST_URI;
                    else if (is_token_byte(b))
                        cl = CL_METHOD;
                    else
                        st = RS_ERR;
                ST_URI_START:
                    if (is_control_byte(b))
                        st = RS_ERR;
                    else
                    begin
                        nxt = ST_URI;
                        cl = CL_URI;
                    end
                ST_URI:
                    if (b == CHAR_SP)
                        nxt = ST_VER_H;
                    else if (is_control_byte(b))
                        st = RS_ERR;
                    else
                        cl = CL_URI;
                ST_VER_H:
                    if (b == CHAR_H) nxt = ST_VER_T1; else st = RS_ERR;
                ST_VER_T1:
                    if (b == CHAR_T) nxt = ST_VER_T2; else st = RS_ERR;
                ST_VER_T2:
                    if (b == CHAR_T) nxt = ST_VER_P; else st = RS_ERR;
                ST_VER_P:
                    if (b == CHAR_P) nxt = ST_VER_SLASH; else st = RS_ERR;
                ST_VER_SLASH:
                    if (b == CHAR_SLASH)
                    begin
                        major_seen = '0;
                        minor_seen = '0;
                        nxt = ST_MAJOR_START;
                    end
                    else
                        st = RS_ERR;
                ST_MAJOR_START:
                    if (is_digit_byte(b))
                    begin
                        major_seen = add_decimal_digit(major_seen, b);
                        nxt = ST_MAJOR;
                    end
                    else
                        st = RS_ERR;
                ST_MAJOR:
                    if (b == CHAR_DOT)
                        nxt = ST_MINOR_START;
                    else if (is_digit_byte(b))
                        major_seen = add_decimal_digit(major_seen, b);
                    else
                        st = RS_ERR;
                ST_MINOR_START:
                    if (is_digit_byte(b))
                    begin
                        minor_seen = add_decimal_digit(minor_seen, b);
                        nxt = ST_MINOR;
                    end
                    else
                        st = RS_ERR;
                ST_MINOR:
                    if (b == CHAR_CR)
                        nxt = ST_NL1;
                    else if (is_digit_byte(b))
                        minor_seen = add_decimal_digit(minor_seen, b);
                    else
                        st = RS_ERR;
                ST_NL1:
                    if (b == CHAR_LF) nxt = ST_LINE_START; else st = RS_ERR;
                ST_LINE_START:
                    if (b == CHAR_CR)
                        nxt = ST_NL3;
                    else if (hdr_seen && (b == CHAR_SP || b == CHAR_HT))
                        nxt = ST_LWS;
                    else if (is_token_byte(b))
                    begin
                        hdr_seen = 1'b1;
                        nh = 1'b1;
                        cl = CL_HNAME;
                        nxt = ST_HNAME;
                    end
                    else
                        st = RS_ERR;
                ST_LWS:
                    if (b == CHAR_CR)
                        nxt = ST_NL2;
                    else if (b == CHAR_SP || b == CHAR_HT)
                        nxt = ST_LWS;
                    else if (is_control_byte(b))
                        st = RS_ERR;
                    else
                    begin
                        nxt = ST_HVALUE;
                        cl = CL_HVALUE;
                    end
                ST_HNAME:
                    if (b == CHAR_COLON)
                        nxt = ST_SPACE_VALUE;
                    else if (is_token_byte(b))
                        cl = CL_HNAME;
                    else
                        st = RS_ERR;
                ST_SPACE_VALUE:
                    if (b == CHAR_SP) nxt = ST_HVALUE; else st = RS_ERR;
                ST_HVALUE:
                    if (b == CHAR_CR)
                        nxt = ST_NL2;
                    else if (is_control_byte(b))
                        st = RS_ERR;
                    else
                        cl = CL_HVALUE;
                ST_NL2:
                    if (b == CHAR_LF) nxt = ST_LINE_START; else st = RS_ERR;
                ST_NL3:
                    if (b == CHAR_LF)
                    begin
                        if (r.bytes_remaining != 0)
                            nxt = ST_BODY;
                        else
                            st = RS_DONE;
                    end
                    else
                        st = RS_ERR;
                ST_BODY:
                begin
                    cl = CL_BODY;
                    st = (r.bytes_remaining != 0) ? RS_CONT : RS_DONE;
                end
                default:
                    st = RS_ERR;
            endcase
            cur_state = nxt;
        end
        res.status = st;
        res.byte_class = cl;
        res.new_header = nh;
        res.out_byte = b;
        res.version_major = major_seen;
        res.version_minor = minor_seen;
        return res;
    endfunction

    // typed-in results are only used where both versions are still zero
    function automatic stim_row_t make_row(input logic [7:0] b, input logic [15:0] rem,
                                           input logic rs, input logic typed,
                                           input status_t st, input byte_class_t cl);
        stim_row_t row;
        row.req.data_byte = b;
        row.req.bytes_remaining = rem;
        row.req.restart = rs;
        row.typed = typed;
        row.want.status = st;
        row.want.byte_class = cl;
        row.want.new_header = 1'b0;
        row.want.out_byte = b;
        row.want.version_major = '0;
        row.want.version_minor = '0;
        return row;
    endfunction

    function automatic logic [7:0] rand_token_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(33, 126));
        while (!is_token_byte(b));
        return b;
    endfunction

    // printable or high byte, optionally allowing space
    function automatic logic [7:0] rand_text_byte(input logic allow_space);
        logic [7:0] b;
        do
            b = 8'($urandom_range(32, 255));
        while (is_control_byte(b) || (!allow_space && b == CHAR_SP));
        return b;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // offer one request, honoring the burst/gap pattern, and log its expectation
    task automatic send_request(input stim_row_t row);
        result_t predicted;
        int      gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            push <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                    : $urandom_range(1, 12);
        end
        burst_left--;
        push <= 1'b1;
        request <= row.req;
        do
            @(posedge clk);
        while (full);
        predicted = parse_byte(row.req);
        awaited_results.insert(awaited_results.size(), row.typed ? row.want : predicted);
        sent_count++;
    endtask

    // sender goes quiet until every result is back
    task automatic pause_until_drained();
        push <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // restart, then a well-formed request with random content, sometimes broken
    task automatic send_well_formed();
        logic [7:0] msg[$];
        int         n;
        int         k;
        int         extra;
        msg.delete();
        // method, space, uri, space
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++)
            msg.insert(msg.size(), rand_token_byte());
        msg.insert(msg.size(), CHAR_SP);
        n = $urandom_range(1, 5);
        for (k = 0; k < n; k++)
            msg.insert(msg.size(), rand_text_byte(1'b0));
        msg.insert(msg.size(), CHAR_SP);
        // version, with long digit runs now and then to hit saturation
        msg.insert(msg.size(), CHAR_H);
        msg.insert(msg.size(), CHAR_T);
        msg.insert(msg.size(), CHAR_T);
        msg.insert(msg.size(), CHAR_P);
        msg.insert(msg.size(), CHAR_SLASH);
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 2);
        for (k = 0; k < n; k++)
            msg.insert(msg.size(), CHAR_ZERO + 8'($urandom_range(0, 9)));
        msg.insert(msg.size(), CHAR_DOT);
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 2);
        for (k = 0; k < n; k++)
            msg.insert(msg.size(), CHAR_ZERO + 8'($urandom_range(0, 9)));
        msg.insert(msg.size(), CHAR_CR);
        msg.insert(msg.size(), CHAR_LF);
        // header lines, some followed by a continuation line
        repeat ($urandom_range(0, 3))
        begin
            n = $urandom_range(1, 4);
            for (k = 0; k < n; k++)
                msg.insert(msg.size(), rand_token_byte());
            msg.insert(msg.size(), CHAR_COLON);
            msg.insert(msg.size(), CHAR_SP);
            n = $urandom_range(0, 5);
            for (k = 0; k < n; k++)
                msg.insert(msg.size(), rand_text_byte(1'b1));
            msg.insert(msg.size(), CHAR_CR);
            msg.insert(msg.size(), CHAR_LF);
            if ($urandom_range(0, 2) == 0)
            begin
                n = $urandom_range(1, 2);
                for (k = 0; k < n; k++)
                    msg.insert(msg.size(), $urandom_range(0, 1) ? CHAR_SP : CHAR_HT);
                n = $urandom_range(0, 4);
                for (k = 0; k < n; k++)
                    msg.insert(msg.size(), rand_text_byte(1'b1));
                msg.insert(msg.size(), CHAR_CR);
                msg.insert(msg.size(), CHAR_LF);
            end
        end
        // blank line and body
        msg.insert(msg.size(), CHAR_CR);
        msg.insert(msg.size(), CHAR_LF);
        n = $urandom_range(0, 6);
        for (k = 0; k < n; k++)
            msg.insert(msg.size(), 8'($urandom_range(0, 255)));
        // broken sequence: one byte replaced
        if ($urandom_range(0, 4) == 0)
            msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom_range(0, 255));
        // overstated length leaves the body open
        extra = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 60000) : 0;
        send_request(make_row(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                              1'b1, 1'b0, RS_CONT, CL_NONE));
        for (k = 0; k < msg.size(); k++)
            send_request(make_row(msg[k], 16'(msg.size() - 1 - k + extra), 1'b0, 1'b0,
                                  RS_CONT, CL_NONE));
    endtask

    // fully random requests, restarts included
    task automatic send_noise();
        repeat ($urandom_range(1, 8))
            send_request(make_row(8'($urandom_range(0, 255)),
                                  16'($urandom_range(0, 65535)),
                                  $urandom_range(0, 5) == 0, 1'b0, RS_CONT, CL_NONE));
    endtask

    // receiver: pop pattern, long hold-off on demand, result checking
    always @(posedge clk)
    begin : result_side
        result_t want;
        rx_cycle <= rx_cycle + 16'd1;
        if (rst_n && pop && !empty)
        begin
            if (awaited_results.size() == 0)
            begin
                $display("%0t: result with no request waiting for it, out_byte %0h",
                         $time, result.out_byte);
                errors++;
            end
            else
            begin
                want = awaited_results.pop_front();
                check_field("status", 16'(want.status), 16'(result.status));
                check_field("byte_class", 16'(want.byte_class), 16'(result.byte_class));
                check_field("new_header", 16'(want.new_header), 16'(result.new_header));
                check_field("out_byte", 16'(want.out_byte), 16'(result.out_byte));
                check_field("version_major", want.version_major, result.version_major);
                check_field("version_minor", want.version_minor, result.version_minor);
            end
        end
        if (!rst_n)
            pop <= 1'b0;
        else if (stall_toggle != stall_seen)
        begin
            stall_seen <= stall_toggle;
            hold_cycles <= HOLD_OFF_CYCLES;
            pop <= 1'b0;
        end
        else if (hold_cycles != 0)
        begin
            hold_cycles <= hold_cycles - 1;
            pop <= 1'b0;
        end
        else
        begin
            case (rx_cycle[9:8])
                2'd0: pop <= 1'b1;
                2'd1: pop <= 1'($urandom_range(0, 1));
                2'd2: pop <= (rx_cycle[1:0] == 2'd0);
                default: pop <= rx_cycle[4];
            endcase
        end
    end

    // run limit
    initial
    begin
        #10_000_000;
        $display("FAIL http_request_header_parser");
        $finish;
    end

    // main sequence
    initial
    begin : stimulus
        int  drain_wait;
        logic hold_done;
        logic pause_done;
        hold_done = 1'b0;
        pause_done = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: error out of reset, restart, control in uri, a minimal
        // request with a saturating major version, one header and a body byte
        directed_rows.insert(directed_rows.size(),
                             make_row(8'hFF, 16'hFFFF, 1'b0, 1'b1, RS_ERR, CL_NONE));
        directed_rows.insert(directed_rows.size(),
                             make_row(8'h00, 16'h0000, 1'b1, 1'b1, RS_CONT, CL_NONE));
        directed_rows.insert(directed_rows.size(),
                             make_row("A", 16'd30, 1'b0, 1'b1, RS_CONT, CL_METHOD));
        directed_rows.insert(directed_rows.size(),
                             make_row(CHAR_SP, 16'd29, 1'b0, 1'b0, RS_CONT, CL_NONE));
        directed_rows.insert(directed_rows.size(),
                             make_row(CHAR_DEL, 16'd28, 1'b0, 1'b1, RS_ERR, CL_NONE));
        directed_rows.insert(directed_rows.size(),
                             make_row(CHAR_SP, 16'd27, 1'b0, 1'b0, RS_CONT, CL_NONE));
        directed_rows.insert(directed_rows.size(),
                             make_row(CHAR_H, 16'd26, 1'b0, 1'b0, RS_CONT, CL_NONE));
        directed_rows.insert(directed_rows.size(),
                             make_row(CHAR_T, 16'd25, 1'b0, 1'b0, RS_CONT, CL_NONE));
        directed_rows.insert(directed_rows.size(),
                             make_row(CHAR_T, 16'd24, 1'b0, 1'b0, RS_CONT, CL_NONE));
        directed_rows.insert(directed_rows.size(),
                             make_row(CHAR_P, 16'd23, 1'b0, 1'b0, RS_CONT, CL_NONE));
        directed_rows.insert(directed_rows.size(),
                             make_row(CHAR_SLASH, 16'd22, 1'b0, 1'b0, RS_CONT, CL_NONE));
        repeat (5)
            directed_rows.insert(directed_rows.size(),
                                 make_row(CHAR_NINE, 16'd21, 1'b0, 1'b0,
                                          RS_CONT, CL_NONE));
        directed_rows.insert(directed_rows.size(),
                             make_row(CHAR_DOT, 16'd8, 1'b0, 1'b0, RS_CONT, CL_NONE));
        directed_rows.insert(directed_rows.size(),
                             make_row(CHAR_ZERO, 16'd7, 1'b0, 1'b0, RS_CONT, CL_NONE));
        directed_rows.insert(directed_rows.size(),
                             make_row(CHAR_CR, 16'd6, 1'b0, 1'b0, RS_CONT, CL_NONE));
        directed_rows.insert(directed_rows.size(),
                             make_row(CHAR_LF, 16'd5, 1'b0, 1'b0, RS_CONT, CL_NONE));
        directed_rows.insert(directed_rows.size(),
                             make_row("X", 16'd4, 1'b0, 1'b0, RS_CONT, CL_NONE));
        directed_rows.insert(directed_rows.size(),
                             make_row(CHAR_COLON, 16'd4, 1'b0, 1'b0, RS_CONT, CL_NONE));
        directed_rows.insert(directed_rows.size(),
                             make_row(CHAR_SP, 16'd4, 1'b0, 1'b0, RS_CONT, CL_NONE));
        directed_rows.insert(directed_rows.size(),
                             make_row(CHAR_CR, 16'd4, 1'b0, 1'b0, RS_CONT, CL_NONE));
        directed_rows.insert(directed_rows.size(),
                             make_row(CHAR_LF, 16'd3, 1'b0, 1'b0, RS_CONT, CL_NONE));
        directed_rows.insert(directed_rows.size(),
                             make_row(CHAR_CR, 16'd2, 1'b0, 1'b0, RS_CONT, CL_NONE));
        directed_rows.insert(directed_rows.size(),
                             make_row(CHAR_LF, 16'd1, 1'b0, 1'b0, RS_CONT, CL_NONE));
        directed_rows.insert(directed_rows.size(),
                             make_row(8'h80, 16'd0, 1'b0, 1'b0, RS_CONT, CL_NONE));
        foreach (directed_rows[i])
            send_request(directed_rows[i]);
        pause_until_drained();

        // random part
        while (sent_count < RANDOM_ITEMS)
        begin
            // long receiver hold-off while the sender keeps pushing
            if (!hold_done && sent_count >= 400)
            begin
                hold_done = 1'b1;
                stall_toggle <= ~stall_toggle;
                burst_left = 60;
            end
            if (!pause_done && sent_count >= 800)
            begin
                pause_done = 1'b1;
                pause_until_drained();
            end
            if ($urandom_range(0, 9) == 0)
                send_noise();
            else
                send_well_formed();
        end

        // drain and finish
        push <= 1'b0;
        drain_wait = 0;
        while (awaited_results.size() != 0 && drain_wait < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_wait++;
        end
        if (awaited_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, awaited_results.size());
            errors++;
        end
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("PASS http_request_header_parser");
        else
            $display("FAIL http_request_header_parser");
        $finish;
    end

endmodule

// ===== files.f =====
src/hrp_pkg.sv
src/hrp_fifo.sv
src/hrp_front.sv
src/hrp_back.sv
src/http_request_header_parser.sv
tb/http_request_header_parser_tb.sv
